>>> rtl/cle_pkg.sv
// Shared types, character codes and microcode table for the console line editor.
`default_nettype none

package cle_pkg;

   // Default line capacity in bytes
   localparam int CLE_LINE_MAX = 64;

   // Microcode step counter width
   localparam int UPC_W = 4;

   // Character codes
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_HASH  = 8'd35;
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_DEL   = 8'd127;
   localparam logic [7:0] CH_SPACE = 8'd32;

   typedef logic [UPC_W-1:0] upc_type;

   typedef enum logic [2:0] {
      ECHO_NONE,
      ECHO_KEY,
      ECHO_CR,
      ECHO_LF,
      ECHO_HASH,
      ECHO_BS,
      ECHO_SP,
      ECHO_IDX
   } echo_sel_type;

   typedef enum logic [1:0] {
      LAST_NO,
      LAST_YES,
      LAST_LINE_END
   } last_sel_type;

   typedef enum logic [1:0] {
      LEN_HOLD,
      LEN_INC,
      LEN_DEC,
      LEN_CLR
   } len_op_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_CLR,
      IDX_INC
   } idx_op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_IS_CR,
      COND_IS_BS,
      COND_FULL,
      COND_EMPTY,
      COND_LT2,
      COND_MORE
   } cond_type;

   // One control word of the microprogram
   typedef struct packed {
      logic         accept;
      logic         emit;
      echo_sel_type echo_sel;
      logic         line_out;
      last_sel_type last_sel;
      logic         wr;
      len_op_type   len_op;
      idx_op_type   idx_op;
      cond_type     cond;
      upc_type      target;
   } uop_type;

   // Datapath flags seen by the sequencer
   typedef struct packed {
      logic is_cr;
      logic is_bs;
      logic full;
      logic empty;
      logic lt2;
      logic more;
      logic slot_busy;
   } status_type;

   // Step addresses
   localparam upc_type STEP_IDLE        = 4'd0;
   localparam upc_type STEP_DISPATCH_CR = 4'd1;
   localparam upc_type STEP_DISPATCH_BS = 4'd2;
   localparam upc_type STEP_CHECK_FULL  = 4'd3;
   localparam upc_type STEP_STORE       = 4'd4;
   localparam upc_type STEP_BS_CHECK    = 4'd5;
   localparam upc_type STEP_BS_ERASE    = 4'd6;
   localparam upc_type STEP_BS_SPACE    = 4'd7;
   localparam upc_type STEP_BS_BACK     = 4'd8;
   localparam upc_type STEP_CR_CHECK    = 4'd9;
   localparam upc_type STEP_LINE_READ   = 4'd10;
   localparam upc_type STEP_LINE_EMIT   = 4'd11;
   localparam upc_type STEP_LINE_DONE   = 4'd12;
   localparam upc_type STEP_PROMPT_CR   = 4'd13;
   localparam upc_type STEP_PROMPT_LF   = 4'd14;
   localparam upc_type STEP_PROMPT_HASH = 4'd15;

   localparam uop_type UOP_NOP = '{
      accept:   1'b0,
      emit:     1'b0,
      echo_sel: ECHO_NONE,
      line_out: 1'b0,
      last_sel: LAST_NO,
      wr:       1'b0,
      len_op:   LEN_HOLD,
      idx_op:   IDX_HOLD,
      cond:     COND_NEXT,
      target:   STEP_IDLE
   };

   // Microprogram ROM
   function automatic uop_type cle_rom(input upc_type step);
      uop_type w;
      w = UOP_NOP;
      case (step)
         STEP_IDLE: begin
            w.accept = 1'b1;
         end
         STEP_DISPATCH_CR: begin
            w.cond   = COND_IS_CR;
            w.target = STEP_CR_CHECK;
         end
         STEP_DISPATCH_BS: begin
            w.cond   = COND_IS_BS;
            w.target = STEP_BS_CHECK;
         end
         STEP_CHECK_FULL: begin
            w.cond   = COND_FULL;
            w.target = STEP_IDLE;
         end
         STEP_STORE: begin
            w.emit     = 1'b1;
            w.echo_sel = ECHO_KEY;
            w.last_sel = LAST_YES;
            w.wr       = 1'b1;
            w.len_op   = LEN_INC;
            w.cond     = COND_ALWAYS;
            w.target   = STEP_IDLE;
         end
         STEP_BS_CHECK: begin
            w.cond   = COND_EMPTY;
            w.target = STEP_IDLE;
         end
         STEP_BS_ERASE: begin
            w.emit     = 1'b1;
            w.echo_sel = ECHO_BS;
            w.len_op   = LEN_DEC;
         end
         STEP_BS_SPACE: begin
            w.emit     = 1'b1;
            w.echo_sel = ECHO_SP;
         end
         STEP_BS_BACK: begin
            w.emit     = 1'b1;
            w.echo_sel = ECHO_BS;
            w.last_sel = LAST_YES;
            w.cond     = COND_ALWAYS;
            w.target   = STEP_IDLE;
         end
         STEP_CR_CHECK: begin
            w.idx_op = IDX_CLR;
            w.cond   = COND_LT2;
            w.target = STEP_PROMPT_CR;
         end
         STEP_LINE_READ: begin
            w = UOP_NOP;
         end
         STEP_LINE_EMIT: begin
            w.emit     = 1'b1;
            w.echo_sel = ECHO_IDX;
            w.line_out = 1'b1;
            w.last_sel = LAST_LINE_END;
            w.idx_op   = IDX_INC;
            w.cond     = COND_MORE;
            w.target   = STEP_LINE_READ;
         end
         STEP_LINE_DONE: begin
            w.len_op = LEN_CLR;
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         STEP_PROMPT_CR: begin
            w.emit     = 1'b1;
            w.echo_sel = ECHO_CR;
            w.len_op   = LEN_CLR;
         end
         STEP_PROMPT_LF: begin
            w.emit     = 1'b1;
            w.echo_sel = ECHO_LF;
         end
         STEP_PROMPT_HASH: begin
            w.emit     = 1'b1;
            w.echo_sel = ECHO_HASH;
            w.last_sel = LAST_YES;
            w.cond     = COND_ALWAYS;
            w.target   = STEP_IDLE;
         end
         default: begin
            w = UOP_NOP;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> rtl/cle_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/cle_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
`default_nettype none

module cle_sequencer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire cle_pkg::status_type status,
   output cle_pkg::uop_type         uop,
   output logic                     fire
);
   import cle_pkg::*;

   upc_type upc_ff;
   upc_type upc_in;
   logic    take;

   // Fetch the current control word
   assign uop = cle_rom(upc_ff);

   // Hold the step while waiting on an input transfer or a busy result slot
   always_comb begin
      fire = 1'b1;
      if (uop.accept && !req_valid) begin
         fire = 1'b0;
      end
      if (uop.emit && status.slot_busy) begin
         fire = 1'b0;
      end
   end

   // Evaluate the jump condition
   always_comb begin
      case (uop.cond)
         COND_NEXT:   take = 1'b0;
         COND_ALWAYS: take = 1'b1;
         COND_IS_CR:  take = status.is_cr;
         COND_IS_BS:  take = status.is_bs;
         COND_FULL:   take = status.full;
         COND_EMPTY:  take = status.empty;
         COND_LT2:    take = status.lt2;
         COND_MORE:   take = status.more;
         default:     take = 1'b0;
      endcase
   end

   // Advance or jump
   always_comb begin
      upc_in = upc_ff;
      if (fire) begin
         upc_in = take ? uop.target : upc_ff + upc_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/cle_datapath.sv
// Datapath: key register, line length and index counters, line store and result register.
`default_nettype none

module cle_datapath #(
   parameter int LINE_MAX = cle_pkg::CLE_LINE_MAX
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       req_rx_byte,
   input  wire cle_pkg::uop_type uop,
   input  wire logic             fire,
   output cle_pkg::status_type   status,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic                  rsp_echo_valid,
   output logic [7:0]            rsp_echo_byte,
   output logic                  rsp_line_valid,
   output logic [7:0]            rsp_line_byte,
   output logic                  rsp_line_end,
   output logic                  rsp_last
);
   import cle_pkg::*;

   localparam int AW    = $clog2(LINE_MAX);
   localparam int LEN_W = $clog2(LINE_MAX + 1);

   logic [7:0]       key_ff;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;
   logic [AW-1:0]    idx_ff;
   logic [AW-1:0]    idx_in;
   logic [7:0]       rd_data;
   logic             load;

   logic             echo_v;
   logic [7:0]       echo_b;
   logic             last_v;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             echo_valid_ff;
   logic [7:0]       echo_byte_ff;
   logic             line_valid_ff;
   logic [7:0]       line_byte_ff;
   logic             line_end_ff;
   logic             last_ff;

   // Line store
   cle_ram #(
      .WIDTH(8),
      .DEPTH(LINE_MAX)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (fire && uop.wr),
      .wr_addr (len_ff[AW-1:0]),
      .wr_data (key_ff),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Flags for the sequencer
   always_comb begin
      status.is_cr     = (key_ff == CH_CR);
      status.is_bs     = (key_ff == CH_BS) || (key_ff == CH_DEL);
      status.full      = (len_ff == LEN_W'(LINE_MAX));
      status.empty     = (len_ff == '0);
      status.lt2       = (len_ff < LEN_W'(2));
      status.more      = ((LEN_W'(idx_ff) + LEN_W'(1)) != len_ff);
      status.slot_busy = rsp_valid_ff && !rsp_ready;
   end

   assign load = fire && uop.emit;

   // Select the echo byte
   always_comb begin
      echo_v = 1'b1;
      echo_b = 8'd0;
      case (uop.echo_sel)
         ECHO_NONE: echo_v = 1'b0;
         ECHO_KEY:  echo_b = key_ff;
         ECHO_CR:   echo_b = CH_CR;
         ECHO_LF:   echo_b = CH_LF;
         ECHO_HASH: echo_b = CH_HASH;
         ECHO_BS:   echo_b = CH_BS;
         ECHO_SP:   echo_b = CH_SPACE;
         ECHO_IDX: begin
            if (idx_ff == '0) begin
               echo_b = CH_CR;
            end else if (idx_ff == AW'(1)) begin
               echo_b = CH_LF;
            end else begin
               echo_v = 1'b0;
            end
         end
         default:   echo_v = 1'b0;
      endcase
   end

   // Select the last flag
   always_comb begin
      case (uop.last_sel)
         LAST_NO:       last_v = 1'b0;
         LAST_YES:      last_v = 1'b1;
         LAST_LINE_END: last_v = !status.more;
         default:       last_v = 1'b0;
      endcase
   end

   // Update the length and index counters
   always_comb begin
      len_in = len_ff;
      idx_in = idx_ff;
      if (fire) begin
         case (uop.len_op)
            LEN_HOLD: len_in = len_ff;
            LEN_INC:  len_in = len_ff + LEN_W'(1);
            LEN_DEC:  len_in = len_ff - LEN_W'(1);
            LEN_CLR:  len_in = '0;
            default:  len_in = len_ff;
         endcase
         case (uop.idx_op)
            IDX_HOLD: idx_in = idx_ff;
            IDX_CLR:  idx_in = '0;
            IDX_INC:  idx_in = idx_ff + AW'(1);
            default:  idx_in = idx_ff;
         endcase
      end
   end

   // Hold the result until its transfer; drop valid once taken
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (fire && uop.accept) begin
         key_ff <= req_rx_byte;
      end
      if (load) begin
         echo_valid_ff <= echo_v;
         echo_byte_ff  <= echo_v ? echo_b : 8'd0;
         line_valid_ff <= uop.line_out;
         line_byte_ff  <= uop.line_out ? rd_data : 8'd0;
         line_end_ff   <= uop.line_out && !status.more;
         last_ff       <= last_v;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_echo_valid = echo_valid_ff;
   assign rsp_echo_byte  = echo_byte_ff;
   assign rsp_line_valid = line_valid_ff;
   assign rsp_line_byte  = line_byte_ff;
   assign rsp_line_end   = line_end_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

>>> rtl/console_line_editor.sv
// An ordinary byte passes the CR, backspace and full checks and is then echoed and stored.
// A backspace echoes BS, space and BS; a carriage return on a line of under two bytes echoes CR, LF and #.
// A completed line of N bytes sends each line byte through a store read step and an emit
// step in the microprogram loop. Stalls on rsp_ready hold any emit step.
// Reset (synchronous) returns the step counter to idle and clears the line length;
// the line store is not cleared and is ready at once.
`default_nettype none

module console_line_editor #(
   parameter int LINE_MAX = cle_pkg::CLE_LINE_MAX
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_echo_valid,
   output logic [7:0]      rsp_echo_byte,
   output logic            rsp_line_valid,
   output logic [7:0]      rsp_line_byte,
   output logic            rsp_line_end,
   output logic            rsp_last
);
   import cle_pkg::*;

   uop_type    uop;
   status_type status;
   logic       fire;

   // Control sequencer
   cle_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .uop       (uop),
      .fire      (fire)
   );

   // Datapath
   cle_datapath #(
      .LINE_MAX(LINE_MAX)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_rx_byte    (req_rx_byte),
      .uop            (uop),
      .fire           (fire),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_echo_valid (rsp_echo_valid),
      .rsp_echo_byte  (rsp_echo_byte),
      .rsp_line_valid (rsp_line_valid),
      .rsp_line_byte  (rsp_line_byte),
      .rsp_line_end   (rsp_line_end),
      .rsp_last       (rsp_last)
   );

   // Take an input transfer only in the idle step
   assign req_ready = uop.accept;

endmodule

`default_nettype wire

>>> rtl/console_line_editor_checker.sv
// Port-level checker for the console line editor, bound to the top level.
`default_nettype none

module console_line_editor_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [7:0] req_rx_byte,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_echo_valid,
   input wire logic [7:0] rsp_echo_byte,
   input wire logic       rsp_line_valid,
   input wire logic [7:0] rsp_line_byte,
   input wire logic       rsp_line_end,
   input wire logic       rsp_last
);

   // Out of reset: idle and no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   // A transfer in starts work; no second byte in the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken twice in a row");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_echo_byte)
         && $stable(rsp_line_byte) && $stable(rsp_last))
      else $error("stalled result changed");

   // End of line is the last result and carries a line byte
   a_line_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_end |-> rsp_line_valid && rsp_last)
      else $error("line end without line byte or last");

   // Unused fields read zero
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_echo_valid || rsp_echo_byte == 8'd0)
         && (rsp_line_valid || (rsp_line_byte == 8'd0 && !rsp_line_end)))
      else $error("unused result field not zero");

endmodule

bind console_line_editor console_line_editor_checker u_checker (.*);

`default_nettype wire
